FILE: src/bcpu_pkg.sv
// Shared types, operation codes, constants and helpers of the byte CPU execute unit.
package bcpu_pkg;

   localparam int MEM_DEPTH_DEF   = 64;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int REG_COUNT_DEF   = 8;

   localparam int RES_W = 25;

   localparam logic [4:0] MODE_MOV   = 5'd0;
   localparam logic [4:0] MODE_ADD   = 5'd1;
   localparam logic [4:0] MODE_SUB   = 5'd2;
   localparam logic [4:0] MODE_MUL   = 5'd3;
   localparam logic [4:0] MODE_DIV   = 5'd4;
   localparam logic [4:0] MODE_INC   = 5'd5;
   localparam logic [4:0] MODE_DEC   = 5'd6;
   localparam logic [4:0] MODE_INPUT = 5'd7;
   localparam logic [4:0] MODE_DISP  = 5'd8;
   localparam logic [4:0] MODE_LOAD  = 5'd9;
   localparam logic [4:0] MODE_STORE = 5'd10;
   localparam logic [4:0] MODE_PUSH  = 5'd11;
   localparam logic [4:0] MODE_POP   = 5'd12;
   localparam logic [4:0] MODE_FRST  = 5'd13;
   localparam logic [4:0] MODE_SHL   = 5'd14;
   localparam logic [4:0] MODE_SHR   = 5'd15;
   localparam logic [4:0] MODE_ROL   = 5'd16;
   localparam logic [4:0] MODE_ROR   = 5'd17;

   localparam logic [1:0] KIND_IMM = 2'd0;
   localparam logic [1:0] KIND_REG = 2'd1;
   localparam logic [1:0] KIND_MEM = 2'd2;

   localparam logic [2:0] ERR_OK    = 3'd0;
   localparam logic [2:0] ERR_DIV0  = 3'd1;
   localparam logic [2:0] ERR_ADDR  = 3'd2;
   localparam logic [2:0] ERR_UNDER = 3'd3;
   localparam logic [2:0] ERR_OVER  = 3'd4;
   localparam logic [2:0] ERR_HALT  = 3'd5;

   localparam logic signed [RES_W-1:0] BYTE_MAX  = 25'sd127;
   localparam logic signed [RES_W-1:0] BYTE_MIN  = -25'sd128;
   localparam logic signed [RES_W-1:0] UBYTE_MAX = 25'sd255;
   localparam logic signed [RES_W-1:0] WIDE_MIN  = -25'sd256;

   typedef struct packed {
      logic       wr;
      logic [2:0] err;
      logic       disp;
      logic       fclr;
      logic       dwe;
      logic       push;
      logic       pop;
   } exec_type;

   function automatic logic [3:0] calc_flags(input logic signed [RES_W-1:0] r);
      logic [3:0] f;
      f[0] = (r > BYTE_MAX);
      f[1] = (r < BYTE_MIN);
      f[2] = (r > UBYTE_MAX) || (r < WIDE_MIN);
      f[3] = (r == '0);
      return f;
   endfunction

   function automatic logic [7:0] bit_move(input logic [7:0] v, input logic [4:0] mode,
                                           input logic [7:0] n);
      logic [15:0] dbl;
      logic [7:0]  res;
      dbl = {v, v};
      case (mode)
         MODE_SHL: res = (n >= 8'd8) ? 8'd0 : 8'(v << n[2:0]);
         MODE_SHR: res = (n >= 8'd8) ? 8'd0 : (v >> n[2:0]);
         MODE_ROL: res = 8'((dbl << n[2:0]) >> 8);
         default:  res = 8'(dbl >> n[2:0]);
      endcase
      return res;
   endfunction

endpackage

FILE: src/bcpu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bcpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: src/bcpu_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module bcpu_div import bcpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic signed [7:0]  dividend,
   input  logic signed [15:0] divisor,
   output logic              done,
   output logic signed [8:0]  quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  dvd_ff, dvd_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [7:0]  q_ff, q_in;
   logic        neg_ff, neg_in;
   logic [16:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, dvd_ff[7]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         rem_in  = 16'd0;
         dvd_in  = dividend[7] ? 8'(-dividend) : dividend;
         dvs_in  = divisor[15] ? 16'(-divisor) : divisor;
         q_in    = 8'd0;
         neg_in  = dividend[7] ^ divisor[15];
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[6:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            q_in   = {q_ff[6:0], 1'b0};
         end
         dvd_in = {dvd_ff[6:0], 1'b0};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule

FILE: src/byte_cpu_instruction_execute_unit.sv
// Top level of the byte CPU execute unit: sequencer, register file, data memory and stack.
//
//   channel | direction | handshake          | beat carries
//   req_    | in        | req_valid/req_stall | one decoded instruction
//   rsp_    | out       | rsp_valid/rsp_stall | display, error, flags, program count
//
// After acceptance an instruction passes through RDB, ADDR, EXEC and DONE: the destination
// and source registers are read from the register RAM, then the shared data and stack
// RAM, then it executes and commits. A divide waits in DIV for the bit-serial divider
// between EXEC and DONE. A halted machine goes from acceptance straight to DONE.
// Reset clears the registers, flags, program counter, stack fill and halt flag at once;
// the register file and data memory read as zero until written through per-entry valid bits.
// A stalled result is held in the output register; the next instruction is accepted
// meanwhile and waits at commit until the result beat has gone.
module byte_cpu_instruction_execute_unit import bcpu_pkg::*; #(
   parameter int MEM_DEPTH   = MEM_DEPTH_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int REG_COUNT   = REG_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [4:0]        req_mode,
   input  logic [2:0]        req_reg_a,
   input  logic [1:0]        req_operand_kind,
   input  logic signed [15:0] req_operand,
   input  logic [7:0]        req_shift_count,
   input  logic [1:0]        req_flag_select,
   input  logic signed [15:0] req_input_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_display_valid,
   output logic signed [7:0]  rsp_display_value,
   output logic [2:0]        rsp_error_code,
   output logic [3:0]        rsp_flag_bits,
   output logic signed [7:0]  rsp_program_count
);
   localparam int MAW = $clog2(MEM_DEPTH);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int FW  = $clog2(STACK_DEPTH + 1);
   localparam int RAW = $clog2(REG_COUNT);
   localparam int DAW = $clog2(MEM_DEPTH + STACK_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RDB  = 6'b000010,
      ST_ADDR = 6'b000100,
      ST_EXEC = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Latched instruction fields.
   logic [4:0]        mode_ff;
   logic [2:0]        ra_ff;
   logic [1:0]        kind_ff;
   logic signed [15:0] opnd_ff;
   logic [7:0]        cnt_ff;
   logic [1:0]        fsel_ff;
   logic signed [15:0] inval_ff;

   // Operands gathered from the RAMs.
   logic [7:0]     dst_ff, dst_in;
   logic [7:0]     srcr_ff, srcr_in;
   logic           regv_ff, dmv_ff;
   logic           addr_ok_ff, addr_ok_in;
   logic [MAW-1:0] addr_idx_ff, addr_idx_in;

   exec_type                  exec_ff, exec_in;
   logic signed [RES_W-1:0]   res_ff, res_in;

   // Architectural state held in flip-flops.
   logic [3:0]           flags_ff, flags_in;
   logic [7:0]           pc_ff, pc_in;
   logic                 halted_ff, halted_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [REG_COUNT-1:0] reg_valid_ff, reg_valid_in;
   logic [MEM_DEPTH-1:0] dm_valid_ff, dm_valid_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_disp_ff, rsp_disp_in;
   logic [7:0] rsp_dval_ff, rsp_dval_in;
   logic [2:0] rsp_err_ff, rsp_err_in;
   logic [3:0] rsp_flags_ff, rsp_flags_in;
   logic [7:0] rsp_pc_ff, rsp_pc_in;

   // RAM ports.
   logic [RAW-1:0] reg_raddr;
   logic [7:0]     reg_rdata, reg_eff;
   logic           reg_we;
   logic [DAW-1:0] dm_raddr, dm_waddr;
   logic [7:0]     dm_rdata, dm_eff;
   logic           dm_we;
   logic [SAW-1:0] st_raddr, st_waddr;

   logic              div_start, div_done;
   logic signed [8:0]  div_q;

   logic                    accept, commit;
   logic [15:0]             addr_sel;
   logic signed [RES_W-1:0] dst_x, src_x;
   logic signed [15:0]      src16;

   bcpu_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_reg_ram (
      .clock (clock),
      .we    (reg_we),
      .waddr (ra_ff[RAW-1:0]),
      .wdata (res_ff[7:0]),
      .raddr (reg_raddr),
      .rdata (reg_rdata)
   );

   // The data words sit at the bottom of this RAM and the stack entries above them.
   bcpu_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH + STACK_DEPTH)) u_data_ram (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dst_ff),
      .raddr (dm_raddr),
      .rdata (dm_rdata)
   );

   bcpu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dst_ff),
      .divisor  (src16),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // The register RAM reads the destination on acceptance and the source in the following cycle.
   assign reg_raddr = (state_ff == ST_IDLE) ? req_reg_a[RAW-1:0] : opnd_ff[RAW-1:0];
   assign reg_eff   = regv_ff ? reg_rdata : 8'd0;
   assign dm_eff    = dmv_ff ? dm_rdata : 8'd0;

   // Address for mov from memory always comes from a register; load and store follow the kind.
   assign addr_sel = ((mode_ff == MODE_MOV) || (kind_ff == KIND_REG))
                     ? {{8{reg_eff[7]}}, reg_eff} : opnd_ff;
   assign addr_ok_in  = !addr_sel[15] && (addr_sel < 16'(MEM_DEPTH));
   assign addr_idx_in = addr_sel[MAW-1:0];

   assign st_raddr = SAW'(fill_ff - FW'(1));
   assign st_waddr = fill_ff[SAW-1:0];

   // A pop reads the top stack entry; every other instruction reads the data address.
   assign dm_raddr = (mode_ff == MODE_POP) ? DAW'(MEM_DEPTH) + DAW'(st_raddr)
                                           : DAW'(addr_idx_in);
   assign dm_waddr = exec_ff.push ? DAW'(MEM_DEPTH) + DAW'(st_waddr)
                                  : DAW'(addr_idx_ff);

   assign src16 = (kind_ff == KIND_REG) ? {{8{srcr_ff[7]}}, srcr_ff} : opnd_ff;
   assign dst_x = RES_W'($signed(dst_ff));
   assign src_x = RES_W'(src16);

   assign div_start = (state_ff == ST_EXEC) && (mode_ff == MODE_DIV) && (src16 != 16'sd0);

   assign reg_we = commit && exec_ff.wr;
   assign dm_we  = commit && (exec_ff.dwe || exec_ff.push);

   always_comb begin
      state_in = state_ff;
      dst_in   = dst_ff;
      srcr_in  = srcr_ff;
      exec_in  = exec_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exec_in = '0;
               if (halted_ff) begin
                  exec_in.err = ERR_HALT;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_RDB;
               end
            end
         end
         ST_RDB: begin
            dst_in   = reg_eff;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            srcr_in  = reg_eff;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (mode_ff)
               MODE_MOV: begin
                  if (kind_ff == KIND_REG) begin
                     exec_in.wr = 1'b1;
                     res_in     = RES_W'($signed(srcr_ff));
                  end else if (kind_ff == KIND_MEM) begin
                     if (!addr_ok_ff) begin
                        exec_in.err = ERR_ADDR;
                     end else begin
                        exec_in.wr = 1'b1;
                        res_in     = RES_W'($signed(dm_eff));
                     end
                  end else begin
                     exec_in.wr = 1'b1;
                     res_in     = RES_W'(opnd_ff);
                  end
               end
               MODE_ADD: begin
                  exec_in.wr = 1'b1;
                  res_in     = dst_x + src_x;
               end
               MODE_SUB: begin
                  exec_in.wr = 1'b1;
                  res_in     = dst_x - src_x;
               end
               MODE_MUL: begin
                  exec_in.wr = 1'b1;
                  res_in     = dst_x * src_x;
               end
               MODE_DIV: begin
                  if (src16 == 16'sd0) begin
                     exec_in.err = ERR_DIV0;
                  end else begin
                     exec_in.wr = 1'b1;
                     state_in   = ST_DIV;
                  end
               end
               MODE_INC: begin
                  exec_in.wr = 1'b1;
                  res_in     = dst_x + RES_W'(1);
               end
               MODE_DEC: begin
                  exec_in.wr = 1'b1;
                  res_in     = dst_x - RES_W'(1);
               end
               MODE_INPUT: begin
                  exec_in.wr = 1'b1;
                  res_in     = RES_W'(inval_ff);
               end
               MODE_DISP: begin
                  exec_in.disp = 1'b1;
               end
               MODE_LOAD: begin
                  if (!addr_ok_ff) begin
                     exec_in.err = ERR_ADDR;
                  end else begin
                     exec_in.wr = 1'b1;
                     res_in     = RES_W'($signed(dm_eff));
                  end
               end
               MODE_STORE: begin
                  if (!addr_ok_ff) begin
                     exec_in.err = ERR_ADDR;
                  end else begin
                     exec_in.dwe = 1'b1;
                  end
               end
               MODE_PUSH: begin
                  if (fill_ff >= FW'(STACK_DEPTH)) begin
                     exec_in.err = ERR_OVER;
                  end else begin
                     exec_in.push = 1'b1;
                  end
               end
               MODE_POP: begin
                  if (fill_ff == '0) begin
                     exec_in.err = ERR_UNDER;
                  end else begin
                     exec_in.pop = 1'b1;
                     exec_in.wr  = 1'b1;
                     res_in      = RES_W'($signed(dm_rdata));
                  end
               end
               MODE_FRST: begin
                  exec_in.fclr = 1'b1;
               end
               MODE_SHL, MODE_SHR, MODE_ROL, MODE_ROR: begin
                  exec_in.wr = 1'b1;
                  res_in     = RES_W'($signed(bit_move(dst_ff, mode_ff, cnt_ff)));
               end
               default: begin
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = RES_W'(div_q);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commit: all architectural updates and the result beat happen together.
   always_comb begin
      flags_in     = flags_ff;
      pc_in        = pc_ff;
      halted_in    = halted_ff;
      fill_in      = fill_ff;
      reg_valid_in = reg_valid_ff;
      dm_valid_in  = dm_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_disp_in  = rsp_disp_ff;
      rsp_dval_in  = rsp_dval_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_pc_in    = rsp_pc_ff;
      if (commit) begin
         if (exec_ff.wr) begin
            flags_in                      = calc_flags(res_ff);
            reg_valid_in[ra_ff[RAW-1:0]] = 1'b1;
         end
         if (exec_ff.fclr) begin
            flags_in = flags_ff & ~(4'b0001 << fsel_ff);
         end
         if (exec_ff.dwe) begin
            dm_valid_in[addr_idx_ff] = 1'b1;
         end
         if (exec_ff.push) begin
            fill_in = fill_ff + FW'(1);
         end
         if (exec_ff.pop) begin
            fill_in = fill_ff - FW'(1);
         end
         if (exec_ff.err inside {ERR_DIV0, ERR_ADDR, ERR_UNDER}) begin
            halted_in = 1'b1;
         end
         if (exec_ff.err inside {ERR_OK, ERR_OVER}) begin
            pc_in = pc_ff + 8'd1;
         end
         rsp_valid_in = 1'b1;
         rsp_disp_in  = exec_ff.disp;
         rsp_dval_in  = exec_ff.disp ? dst_ff : 8'd0;
         rsp_err_in   = exec_ff.err;
         rsp_flags_in = flags_in;
         rsp_pc_in    = pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         fill_ff      <= '0;
         reg_valid_ff <= '0;
         dm_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         fill_ff      <= fill_in;
         reg_valid_ff <= reg_valid_in;
         dm_valid_ff  <= dm_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         mode_ff  <= req_mode;
         ra_ff    <= req_reg_a;
         kind_ff  <= req_operand_kind;
         opnd_ff  <= req_operand;
         cnt_ff   <= req_shift_count;
         fsel_ff  <= req_flag_select;
         inval_ff <= req_input_value;
      end
      regv_ff <= reg_valid_ff[reg_raddr];
      if (state_ff == ST_ADDR) begin
         dmv_ff      <= dm_valid_ff[addr_idx_in];
         addr_ok_ff  <= addr_ok_in;
         addr_idx_ff <= addr_idx_in;
      end
      dst_ff       <= dst_in;
      srcr_ff      <= srcr_in;
      exec_ff      <= exec_in;
      res_ff       <= res_in;
      rsp_disp_ff  <= rsp_disp_in;
      rsp_dval_ff  <= rsp_dval_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_pc_ff    <= rsp_pc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_display_valid = rsp_disp_ff;
   assign rsp_display_value = rsp_dval_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_flag_bits     = rsp_flags_ff;
   assign rsp_program_count = rsp_pc_ff;
endmodule

FILE: test/byte_cpu_instruction_execute_unit_tb.sv
// Self-checking testbench for the byte CPU instruction execute unit.
module byte_cpu_instruction_execute_unit_tb;
   import bcpu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEM_D     = 64;
   localparam int STACK_D   = 64;
   localparam int N_RANDOM  = 1350;
   localparam int CYCLE_MAX = 600000;

   // One decoded instruction, as carried by a request beat.
   typedef struct packed {
      logic [4:0]        mode;
      logic [2:0]        reg_a;
      logic [1:0]        kind;
      logic signed [15:0] operand;
      logic [7:0]        shift;
      logic [1:0]        fsel;
      logic signed [15:0] inval;
   } instr_type;

   // One result beat.
   typedef struct packed {
      logic       dv;
      logic [7:0] dval;
      logic [2:0] err;
      logic [3:0] flags;
      logic [7:0] pc;
   } outcome_type;

   typedef struct packed {
      instr_type   ins;
      logic        typed;
      outcome_type exp;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [4:0]        req_mode = '0;
   logic [2:0]        req_reg_a = '0;
   logic [1:0]        req_operand_kind = '0;
   logic signed [15:0] req_operand = '0;
   logic [7:0]        req_shift_count = '0;
   logic [1:0]        req_flag_select = '0;
   logic signed [15:0] req_input_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_display_valid;
   logic signed [7:0]  rsp_display_value;
   logic [2:0]        rsp_error_code;
   logic [3:0]        rsp_flag_bits;
   logic signed [7:0]  rsp_program_count;

   byte_cpu_instruction_execute_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_reg_a         (req_reg_a),
      .req_operand_kind  (req_operand_kind),
      .req_operand       (req_operand),
      .req_shift_count   (req_shift_count),
      .req_flag_select   (req_flag_select),
      .req_input_value   (req_input_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_display_valid (rsp_display_valid),
      .rsp_display_value (rsp_display_value),
      .rsp_error_code    (rsp_error_code),
      .rsp_flag_bits     (rsp_flag_bits),
      .rsp_program_count (rsp_program_count)
   );

   // The clock runs with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow machine state, updated as each instruction beat is accepted.
   logic [7:0] m_regs [8];
   logic [7:0] m_mem [MEM_D];
   logic [7:0] m_stack [STACK_D];
   logic [3:0] m_flags;
   logic [7:0] m_pc;
   int         m_fill;
   logic       m_halted;

   outcome_type pending_results [$];
   int  fail_count = 0;
   int  beats_sent = 0;
   int  beats_seen = 0;
   int  cycle_count = 0;
   int  displays_seen = 0;
   int  overflows_seen = 0;
   bit  idle_on = 1'b0;

   function automatic int sbyte(input logic [7:0] b);
      return int'($signed(b));
   endfunction

   // Flags come from the full-width result; the register keeps only its low byte.
   function automatic void write_flagged(input logic [2:0] idx, input int r);
      m_flags[0] = (r > 127);
      m_flags[1] = (r < -128);
      m_flags[2] = (r > 255) || (r < -256);
      m_flags[3] = (r == 0);
      m_regs[idx] = r[7:0];
   endfunction

   function automatic logic [7:0] shifted(input logic [7:0] v, input logic [4:0] mode,
                                         input logic [7:0] n);
      logic [2:0] k;
      k = n[2:0];
      case (mode)
         MODE_SHL: return (n >= 8) ? 8'd0 : v << n;
         MODE_SHR: return (n >= 8) ? 8'd0 : v >> n;
         MODE_ROL: return (k == 0) ? v : (v << k) | (v >> (4'd8 - k));
         default:  return (k == 0) ? v : (v >> k) | (v << (4'd8 - k));
      endcase
   endfunction

   // Address that a mov-from-memory, load or store would use.
   function automatic int target_addr(input instr_type i);
      if (i.mode == MODE_MOV || i.kind == KIND_REG)
         return sbyte(m_regs[i.operand[2:0]]);
      return int'(i.operand);
   endfunction

   // True when the instruction would stop the machine with a fatal error.
   function automatic bit stops_machine(input instr_type i);
      int src;
      src = (i.kind == KIND_REG) ? sbyte(m_regs[i.operand[2:0]]) : int'(i.operand);
      case (i.mode)
         MODE_MOV:             return i.kind == KIND_MEM &&
                                      !(target_addr(i) inside {[0:MEM_D-1]});
         MODE_DIV:             return src == 0;
         MODE_LOAD, MODE_STORE: return !(target_addr(i) inside {[0:MEM_D-1]});
         MODE_POP:             return m_fill == 0;
         default:              return 1'b0;
      endcase
   endfunction

   // Executes one instruction on the shadow state and returns its result beat.
   function automatic outcome_type execute_instr(input instr_type i);
      outcome_type o;
      int dst, src, a;
      o = '0;
      dst = sbyte(m_regs[i.reg_a]);
      src = (i.kind == KIND_REG) ? sbyte(m_regs[i.operand[2:0]]) : int'(i.operand);
      if (m_halted) begin
         o.err = ERR_HALT;
      end else begin
         case (i.mode)
            MODE_MOV:
               if (i.kind == KIND_REG) write_flagged(i.reg_a, sbyte(m_regs[i.operand[2:0]]));
               else if (i.kind == KIND_MEM) begin
                  a = target_addr(i);
                  if (!(a inside {[0:MEM_D-1]})) o.err = ERR_ADDR;
                  else write_flagged(i.reg_a, sbyte(m_mem[a]));
               end else write_flagged(i.reg_a, int'(i.operand));
            MODE_ADD: write_flagged(i.reg_a, dst + src);
            MODE_SUB: write_flagged(i.reg_a, dst - src);
            MODE_MUL: write_flagged(i.reg_a, dst * src);
            MODE_DIV:
               if (src == 0) o.err = ERR_DIV0;
               else write_flagged(i.reg_a, dst / src);
            MODE_INC:   write_flagged(i.reg_a, dst + 1);
            MODE_DEC:   write_flagged(i.reg_a, dst - 1);
            MODE_INPUT: write_flagged(i.reg_a, int'(i.inval));
            MODE_DISP: begin
               o.dv = 1'b1;
               o.dval = m_regs[i.reg_a];
            end
            MODE_LOAD, MODE_STORE: begin
               a = target_addr(i);
               if (!(a inside {[0:MEM_D-1]})) o.err = ERR_ADDR;
               else if (i.mode == MODE_LOAD) write_flagged(i.reg_a, sbyte(m_mem[a]));
               else m_mem[a] = m_regs[i.reg_a];
            end
            MODE_PUSH:
               if (m_fill >= STACK_D) o.err = ERR_OVER;
               else begin
                  m_stack[m_fill] = m_regs[i.reg_a];
                  m_fill++;
               end
            MODE_POP:
               if (m_fill == 0) o.err = ERR_UNDER;
               else begin
                  m_fill--;
                  write_flagged(i.reg_a, sbyte(m_stack[m_fill]));
               end
            MODE_FRST: m_flags[i.fsel] = 1'b0;
            MODE_SHL, MODE_SHR, MODE_ROL, MODE_ROR:
               write_flagged(i.reg_a, sbyte(shifted(m_regs[i.reg_a], i.mode, i.shift)));
            default: ;
         endcase
         if (o.err inside {ERR_DIV0, ERR_ADDR, ERR_UNDER}) m_halted = 1'b1;
         else m_pc = m_pc + 8'd1;
      end
      o.flags = m_flags;
      o.pc = m_pc;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("MISMATCH result %0d %s: got %0d expected %0d", beats_seen, what, got, want);
      fail_count++;
   endtask

   // Drives one instruction beat, holds it until accepted and records its result.
   task automatic send_instr(input instr_type i, input bit typed, input outcome_type want);
      outcome_type o;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= i.mode;
      req_reg_a        <= i.reg_a;
      req_operand_kind <= i.kind;
      req_operand      <= i.operand;
      req_shift_count  <= i.shift;
      req_flag_select  <= i.fsel;
      req_input_value  <= i.inval;
      do @(posedge clock); while (req_stall);
      o = execute_instr(i);
      pending_results.push_back(typed ? want : o);
      beats_sent++;
   endtask

   // Random instruction over the full field range; phases 1 and 2 narrow the mode.
   function automatic instr_type random_instr(input int phase);
      instr_type i;
      i.mode    = 5'($urandom_range(0, 17));
      if ($urandom_range(0, 40) == 0) i.mode = 5'($urandom_range(18, 31));
      if (phase == 1) i.mode = MODE_PUSH;
      if (phase == 2) i.mode = ($urandom_range(0, 3) != 0) ? MODE_POP : MODE_DISP;
      i.reg_a   = 3'($urandom);
      i.kind    = 2'($urandom);
      i.operand = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, MEM_D - 1)) : 16'($urandom);
      i.shift   = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom);
      i.fsel    = 2'($urandom);
      i.inval   = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 300)) - 16'sd150
                                              : 16'($urandom);
      return i;
   endfunction

   // Result side: checks every accepted beat and stalls in random bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing outstanding", 8'd0, 8'd0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_display_valid !== w.dv) report_mismatch("display_valid", rsp_display_valid, w.dv);
            if (rsp_display_value !== w.dval) report_mismatch("display_value", rsp_display_value, w.dval);
            if (rsp_error_code !== w.err) report_mismatch("error_code", rsp_error_code, w.err);
            if (rsp_flag_bits !== w.flags) report_mismatch("flag_bits", rsp_flag_bits, w.flags);
            if (rsp_program_count !== w.pc) report_mismatch("program_count", rsp_program_count, w.pc);
            if (w.dv) displays_seen++;
            if (w.err == ERR_OVER) overflows_seen++;
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Directed rows. Rows marked typed carry a result that follows plainly from the
   // instruction and the state before it; the others go through the shadow machine.
   // Fields: mode, reg, kind, operand, shift, flag select, input value, typed, result.
   vector_type directed [] = '{
      // Move of zero from reset: only the zero flag, counter at one.
      '{'{MODE_MOV,   3'd0, KIND_IMM, 16'sd0,      8'd0,   2'd0, 16'sd0},      1'b1,
        '{1'b0, 8'd0,   ERR_OK, 4'b1000, 8'd1}},
      // Largest input: overflow and carry set.
      '{'{MODE_INPUT, 3'd1, KIND_IMM, 16'sd0,      8'd0,   2'd0, 16'sd32767},  1'b1,
        '{1'b0, 8'd0,   ERR_OK, 4'b0101, 8'd2}},
      // Most negative input: underflow and carry set.
      '{'{MODE_INPUT, 3'd2, KIND_IMM, 16'sd0,      8'd0,   2'd3, -16'sd32768}, 1'b1,
        '{1'b0, 8'd0,   ERR_OK, 4'b0110, 8'd3}},
      // 32767 wraps to all ones in the register.
      '{'{MODE_DISP,  3'd1, KIND_IMM, 16'sd0,      8'd0,   2'd0, 16'sd0},      1'b1,
        '{1'b1, 8'hff,  ERR_OK, 4'b0110, 8'd4}},
      '{'{MODE_ADD,   3'd1, KIND_REG, 16'sd2,      8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_SUB,   3'd3, KIND_IMM, -16'sd32768, 8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_MUL,   3'd2, KIND_IMM, 16'sd32767,  8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_DIV,   3'd1, KIND_IMM, -16'sd3,     8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_INC,   3'd4, KIND_IMM, 16'sd0,      8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_DEC,   3'd5, KIND_IMM, 16'sd0,      8'd0,   2'd0, 16'sd0},      1'b0, '0},
      // Store and load at the top address.
      '{'{MODE_STORE, 3'd1, KIND_IMM, 16'sd63,     8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_LOAD,  3'd6, KIND_IMM, 16'sd63,     8'd0,   2'd0, 16'sd0},      1'b0, '0},
      // Move from memory through a register holding the address.
      '{'{MODE_MOV,   3'd0, KIND_IMM, 16'sd63,     8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_MOV,   3'd7, KIND_MEM, 16'sd8,      8'd0,   2'd0, 16'sd0},      1'b0, '0},
      // Operand kind three behaves as an immediate.
      '{'{MODE_ADD,   3'd0, 2'd3,     16'sd5,      8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_PUSH,  3'd1, KIND_IMM, 16'sd0,      8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_POP,   3'd3, KIND_IMM, 16'sd0,      8'd0,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_FRST,  3'd0, KIND_IMM, 16'sd0,      8'd0,   2'd3, 16'sd0},      1'b0, '0},
      '{'{MODE_FRST,  3'd0, KIND_IMM, 16'sd0,      8'd0,   2'd2, 16'sd0},      1'b0, '0},
      // Shift counts of eight or more clear; rotates use the count modulo eight.
      '{'{MODE_SHL,   3'd1, KIND_IMM, 16'sd0,      8'd255, 2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_SHR,   3'd6, KIND_IMM, 16'sd0,      8'd3,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_ROL,   3'd2, KIND_IMM, 16'sd0,      8'd9,   2'd0, 16'sd0},      1'b0, '0},
      '{'{MODE_ROR,   3'd3, KIND_IMM, 16'sd0,      8'd200, 2'd1, 16'sd0},      1'b0, '0},
      // An unknown operation only advances the counter.
      '{'{5'd31,      3'd7, 2'd3,     -16'sd1,     8'd0,   2'd0, 16'sd0},      1'b0, '0}
   };

   initial begin
      instr_type i;
      int fatal_pick;
      m_regs = '{default: '0};
      m_mem = '{default: '0};
      m_stack = '{default: '0};
      m_flags = '0;
      m_pc = '0;
      m_fill = 0;
      m_halted = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[n]) send_instr(directed[n].ins, directed[n].typed, directed[n].exp);

      // Let the pipeline drain completely before the random traffic starts.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);

      idle_on = 1'b1;
      for (int n = 0; n < N_RANDOM; n++) begin
         // A run of pushes past the stack depth, then a run of pops and displays,
         // both with random content, and full-speed traffic over the last stretch.
         if (n == N_RANDOM - 150) idle_on = 1'b0;
         do
            i = random_instr((n >= 400 && n < 470) ? 1 : (n >= 470 && n < 560) ? 2 : 0);
         while (stops_machine(i));
         send_instr(i, 1'b0, '0);
      end

      // One fatal error, chosen by the seed, then a few beats on the stopped machine.
      fatal_pick = $urandom_range(0, 2);
      i = random_instr(0);
      i.kind = KIND_IMM;
      if (fatal_pick == 0) begin
         i.mode = MODE_DIV;
         i.operand = 16'sd0;
      end else if (fatal_pick == 1) begin
         i.mode = MODE_LOAD;
         i.operand = ($urandom_range(0, 1) != 0) ? 16'sd64 : -16'sd1;
      end else begin
         while (m_fill > 0) begin
            i.mode = MODE_POP;
            send_instr(i, 1'b0, '0);
         end
         i.mode = MODE_POP;
      end
      send_instr(i, 1'b0, '0);
      repeat (4) send_instr(random_instr(0), 1'b0, '0);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d instruction beats sent, %0d results checked (%0d displays, %0d stack overflows)",
               beats_sent, beats_seen, displays_seen, overflows_seen);
      $display("all operations, stack fill and drain, random stalls, fatal error %0d",
               fatal_pick);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results outstanding", fail_count, pending_results.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
